// File: sv/hsvbgr_pkg.sv
// hsvbgr_pkg: shared constants and types for the hsv to bgr color pipeline
// no dependencies; imported by hsvbgr_hash and hsv_to_bgr_color_top
`default_nettype none

package hsvbgr_pkg;

  // fixed point format of hue, saturation and value
  localparam int FRAC_BITS = 16;
  localparam int FIELD_W   = FRAC_BITS + 1;
  localparam logic [FIELD_W-1:0] FIX_ONE = FIELD_W'(1) << FRAC_BITS;

  // object id hashing
  localparam int ID_W = 32;
  localparam logic [ID_W-1:0] HASH_MASK_HUE = 32'h0093_7151;
  localparam logic [ID_W-1:0] HASH_MASK_SAT = 32'h0031_5793;
  localparam int HASH_MOD = 100;
  localparam int REM_W    = 7;

  // floor(x / 100) = (x * DIV_MAGIC) >> DIV_SHIFT, exact for any 32-bit x
  localparam logic [ID_W-1:0] DIV_MAGIC = 32'h51EB_851F;
  localparam int DIV_SHIFT = 37;
  localparam int QUO_W     = 2 * ID_W - DIV_SHIFT;

  // hue sector decoding
  localparam int SECTORS  = 6;
  localparam int H6_W     = FIELD_W + 3;
  localparam int SECTOR_W = H6_W - FRAC_BITS;

  typedef logic [SECTOR_W-1:0] sector_t;

  localparam sector_t SECT_RED_YELLOW    = SECTOR_W'(0);
  localparam sector_t SECT_YELLOW_GREEN  = SECTOR_W'(1);
  localparam sector_t SECT_GREEN_CYAN    = SECTOR_W'(2);
  localparam sector_t SECT_CYAN_BLUE     = SECTOR_W'(3);
  localparam sector_t SECT_BLUE_MAGENTA  = SECTOR_W'(4);
  localparam sector_t SECT_MAGENTA_RED   = SECTOR_W'(5);

  // products of two levels
  localparam int PROD_W = 2 * FIELD_W;

  typedef logic [FIELD_W-1:0] level_t;

endpackage

`default_nettype wire

// File: sv/hsvbgr_hash.sv
// hsvbgr_hash: object id to hue and saturation, mod 100 by reciprocal multiply
// depends on hsvbgr_pkg; registers the hash and quotient, then the remainder
`default_nettype none

module hsvbgr_hash
  import hsvbgr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [ID_W-1:0]   object_id,
  output level_t                 hash_hue,
  output level_t                 hash_sat
);

  localparam int NUM_W = REM_W + FRAC_BITS;
  localparam int SCL_W = NUM_W + ID_W;

  logic [ID_W-1:0]   hx_nxt, sx_nxt, hx_r, sx_r;
  logic [2*ID_W-1:0] hx_prod, sx_prod;
  logic [QUO_W-1:0]  hq_nxt, sq_nxt, hq_r, sq_r;
  logic [ID_W-1:0]   hq_ext, sq_ext, hq100, sq100, hrem, srem;
  logic [REM_W-1:0]  rh_nxt, rs_nxt, rh_r, rs_r;
  logic [NUM_W-1:0]  hnum, snum;
  logic [SCL_W-1:0]  hscl, sscl;

  // stage 1: hash and quotient estimate
  assign hx_nxt  = (object_id << 2) ^ HASH_MASK_HUE;
  assign sx_nxt  = (object_id << 3) ^ HASH_MASK_SAT;
  assign hx_prod = (2*ID_W)'(hx_nxt) * (2*ID_W)'(DIV_MAGIC);
  assign sx_prod = (2*ID_W)'(sx_nxt) * (2*ID_W)'(DIV_MAGIC);
  assign hq_nxt  = hx_prod[DIV_SHIFT +: QUO_W];
  assign sq_nxt  = sx_prod[DIV_SHIFT +: QUO_W];

  // stage 2: remainder, x - 100 * q
  assign hq_ext = ID_W'(hq_r);
  assign sq_ext = ID_W'(sq_r);
  assign hq100  = (hq_ext << 6) + (hq_ext << 5) + (hq_ext << 2);
  assign sq100  = (sq_ext << 6) + (sq_ext << 5) + (sq_ext << 2);
  assign hrem   = hx_r - hq100;
  assign srem   = sx_r - sq100;
  assign rh_nxt = hrem[REM_W-1:0];
  assign rs_nxt = srem[REM_W-1:0];

  always_ff @(posedge clk) begin
    hx_r <= hx_nxt;
    sx_r <= sx_nxt;
    hq_r <= hq_nxt;
    sq_r <= sq_nxt;
    rh_r <= rh_nxt;
    rs_r <= rs_nxt;
  end

  // scale remainder to a fraction: floor(r * one / 100)
  assign hnum = {rh_r, FRAC_BITS'(0)};
  assign snum = {rs_r, FRAC_BITS'(0)};
  assign hscl = SCL_W'(hnum) * SCL_W'(DIV_MAGIC);
  assign sscl = SCL_W'(snum) * SCL_W'(DIV_MAGIC);

  assign hash_hue = hscl[DIV_SHIFT +: FIELD_W];
  assign hash_sat = sscl[DIV_SHIFT +: FIELD_W];

endmodule

`default_nettype wire

// File: sv/hsv_to_bgr_color_top.sv
// hsv_to_bgr_color_top: six stage pipeline, one request per cycle
// a request taken at an edge passes through stages 1 to 6 and shows its color with out_valid
// busy is tied low; the receiver cannot stall, so nothing ever backs up
// rst_n (synchronous, active low) clears the valid bits only
// depends on hsvbgr_pkg and hsvbgr_hash
`default_nettype none

module hsv_to_bgr_color_top
  import hsvbgr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              in_action,
  input  wire logic [ID_W-1:0]   in_object_id,
  input  wire logic [FIELD_W-1:0] in_hue,
  input  wire logic [FIELD_W-1:0] in_saturation,
  input  wire logic [FIELD_W-1:0] in_brightness,
  output logic                   out_valid,
  output logic [7:0]             out_blue,
  output logic [7:0]             out_green,
  output logic [7:0]             out_red
);

  localparam int BYTE_W = 8;
  localparam int SCL_W  = FIELD_W + BYTE_W;

  // truncated level * 255 / one, done as shift and subtract
  function automatic logic [BYTE_W-1:0] level_to_byte(input level_t level);
    logic [SCL_W-1:0] scaled;
    scaled = (SCL_W'(level) << BYTE_W) - SCL_W'(level);
    return scaled[FRAC_BITS +: BYTE_W];
  endfunction

  // valid bits for stages 1 to 5; stage 6 is out_valid_r
  logic [4:0] vld_r, vld_nxt;

  // stages 1 and 2: mode and direct inputs ride beside the hash unit
  logic   act_s1_r, act_s2_r;
  level_t hue_s1_r, sat_s1_r, val_s1_r;
  level_t hue_s2_r, sat_s2_r, val_s2_r;
  level_t sat_in_nxt, val_in_nxt;

  // hash results, valid alongside stage 2
  level_t hash_hue, hash_sat;

  // stage 3: chosen hue, saturation and value
  level_t hue_s3_r, sat_s3_r, val_s3_r;
  level_t hue_s3_nxt, sat_s3_nxt, val_s3_nxt;

  // stage 4: sector and the two saturation products
  logic [H6_W-1:0]     h6;
  logic [FRAC_BITS-1:0] frac;
  level_t              one_m_f;
  sector_t             sect_s4_r, sect_s5_r;
  logic [PROD_W-1:0]   fs_s4_r, gs_s4_r, fs_s4_nxt, gs_s4_nxt;
  level_t              omsat_s4_r, val_s4_r, val_s5_r;

  // stage 5: the three mix levels
  level_t            adj_q, adj_t;
  logic [PROD_W-1:0] p_prod, q_prod, t_prod;
  level_t            p_s5_r, q_s5_r, t_s5_r;

  // stage 6: channel select and byte scaling
  level_t           lvl_r, lvl_g, lvl_b;
  logic             out_valid_r;
  logic [BYTE_W-1:0] blue_r, green_r, red_r;

  // the pipeline never holds off a request
  assign busy = 1'b0;

  // request enters when start is high, shifts one stage per cycle
  assign vld_nxt = {vld_r[3:0], start & ~busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      out_valid_r <= vld_r[4];
    end
  end

  // saturation and value above 1.0 clamp to 1.0
  assign sat_in_nxt = (in_saturation > FIX_ONE) ? FIX_ONE : in_saturation;
  assign val_in_nxt = (in_brightness > FIX_ONE) ? FIX_ONE : in_brightness;

  hsvbgr_hash u_hash (
    .clk       (clk),
    .object_id (in_object_id),
    .hash_hue  (hash_hue),
    .hash_sat  (hash_sat)
  );

  // mode select: id mode takes hashed hue and saturation at full value
  assign hue_s3_nxt = act_s2_r ? hash_hue : hue_s2_r;
  assign sat_s3_nxt = act_s2_r ? hash_sat : sat_s2_r;
  assign val_s3_nxt = act_s2_r ? FIX_ONE  : val_s2_r;

  // hue * 6 splits into sector (integer part) and position within it
  assign h6      = (H6_W'(hue_s3_r) << 2) + (H6_W'(hue_s3_r) << 1);
  assign frac    = h6[FRAC_BITS-1:0];
  assign one_m_f = FIX_ONE - FIELD_W'(frac);

  assign fs_s4_nxt = PROD_W'(frac) * PROD_W'(sat_s3_r);
  assign gs_s4_nxt = PROD_W'(one_m_f) * PROD_W'(sat_s3_r);

  // p = v(1-s), q = v(1-fs), t = v(1-(1-f)s)
  assign adj_q  = FIX_ONE - fs_s4_r[FRAC_BITS +: FIELD_W];
  assign adj_t  = FIX_ONE - gs_s4_r[FRAC_BITS +: FIELD_W];
  assign p_prod = PROD_W'(val_s4_r) * PROD_W'(omsat_s4_r);
  assign q_prod = PROD_W'(val_s4_r) * PROD_W'(adj_q);
  assign t_prod = PROD_W'(val_s4_r) * PROD_W'(adj_t);

  always_ff @(posedge clk) begin
    // stage 1
    act_s1_r   <= in_action;
    hue_s1_r   <= in_hue;
    sat_s1_r   <= sat_in_nxt;
    val_s1_r   <= val_in_nxt;
    // stage 2
    act_s2_r   <= act_s1_r;
    hue_s2_r   <= hue_s1_r;
    sat_s2_r   <= sat_s1_r;
    val_s2_r   <= val_s1_r;
    // stage 3
    hue_s3_r   <= hue_s3_nxt;
    sat_s3_r   <= sat_s3_nxt;
    val_s3_r   <= val_s3_nxt;
    // stage 4
    sect_s4_r  <= h6[H6_W-1:FRAC_BITS];
    fs_s4_r    <= fs_s4_nxt;
    gs_s4_r    <= gs_s4_nxt;
    omsat_s4_r <= FIX_ONE - sat_s3_r;
    val_s4_r   <= val_s3_r;
    // stage 5
    sect_s5_r  <= sect_s4_r;
    val_s5_r   <= val_s4_r;
    p_s5_r     <= p_prod[FRAC_BITS +: FIELD_W];
    q_s5_r     <= q_prod[FRAC_BITS +: FIELD_W];
    t_s5_r     <= t_prod[FRAC_BITS +: FIELD_W];
    // stage 6
    blue_r     <= level_to_byte(lvl_b);
    green_r    <= level_to_byte(lvl_g);
    red_r      <= level_to_byte(lvl_r);
  end

  // sector picks the channel mix; hue at or past 1.0 gives white
  always_comb begin
    unique case (sect_s5_r)
      SECT_RED_YELLOW: begin
        lvl_r = val_s5_r; lvl_g = t_s5_r;   lvl_b = p_s5_r;
      end
      SECT_YELLOW_GREEN: begin
        lvl_r = q_s5_r;   lvl_g = val_s5_r; lvl_b = p_s5_r;
      end
      SECT_GREEN_CYAN: begin
        lvl_r = p_s5_r;   lvl_g = val_s5_r; lvl_b = t_s5_r;
      end
      SECT_CYAN_BLUE: begin
        lvl_r = p_s5_r;   lvl_g = q_s5_r;   lvl_b = val_s5_r;
      end
      SECT_BLUE_MAGENTA: begin
        lvl_r = t_s5_r;   lvl_g = p_s5_r;   lvl_b = val_s5_r;
      end
      SECT_MAGENTA_RED: begin
        lvl_r = val_s5_r; lvl_g = p_s5_r;   lvl_b = q_s5_r;
      end
      default: begin
        lvl_r = FIX_ONE;  lvl_g = FIX_ONE;  lvl_b = FIX_ONE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_blue  = blue_r;
  assign out_green = green_r;
  assign out_red   = red_r;

endmodule

`default_nettype wire

// File: tb/sv/hsv_to_bgr_color_top_tb.sv
// hsv_to_bgr_color_top_tb: self-checking bench for the hsv / object id to bgr color pipeline
// predicts each request's color bytes in fixed point and checks every out_valid strobe in order
// depends on hsvbgr_pkg and hsv_to_bgr_color_top

module hsv_to_bgr_color_top_tb;
  import hsvbgr_pkg::*;

  // request modes carried on in_action
  localparam logic ACT_HSV       = 1'b0;
  localparam logic ACT_OBJECT_ID = 1'b1;

  // cycles with no request and no color before the run is declared hung
  localparam int STALL_LIMIT  = 2000;
  // pipeline depth from the top level header plus some margin
  localparam int DRAIN_CYCLES = 12;
  localparam int RAND_PER_PHASE = 530;

  typedef struct {
    logic              action;
    logic [ID_W-1:0]   object_id;
    logic [FIELD_W-1:0] hue;
    logic [FIELD_W-1:0] saturation;
    logic [FIELD_W-1:0] brightness;
  } color_req_t;

  typedef struct {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } color_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               in_action;
  logic [ID_W-1:0]    in_object_id;
  logic [FIELD_W-1:0] in_hue;
  logic [FIELD_W-1:0] in_saturation;
  logic [FIELD_W-1:0] in_brightness;
  logic               out_valid;
  logic [7:0]         out_blue;
  logic [7:0]         out_green;
  logic [7:0]         out_red;

  hsv_to_bgr_color_top u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_action     (in_action),
    .in_object_id  (in_object_id),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_brightness (in_brightness),
    .out_valid     (out_valid),
    .out_blue      (out_blue),
    .out_green     (out_green),
    .out_red       (out_red)
  );

  // requests waiting to be driven, colors waiting to come out
  color_req_t pending_reqs[$];
  color_t     expected_colors[$];

  int  idle_pct;        // chance per cycle that the sender leaves start low
  bit  hold_for_drain;  // sender pauses while the pipeline empties
  bit  req_taken;       // request on the ports was taken at the last edge
  bit  failed;
  int  stall_cycles;
  int  n_hsv;
  int  n_object_id;
  int  n_checked;
  int  n_past_hue;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // color predictor
  // ---------------------------------------------------------------------------

  // levels above 1.0 are clipped to 1.0
  function automatic logic [63:0] clip_one(logic [63:0] x);
    logic [63:0] one;
    one = 64'd1 << FRAC_BITS;
    return (x > one) ? one : x;
  endfunction

  // truncated level * 255
  function automatic logic [7:0] level_byte(logic [63:0] lvl);
    logic [63:0] scaled;
    scaled = (clip_one(lvl) * 64'd255) >> FRAC_BITS;
    return scaled[7:0];
  endfunction

  function automatic color_t hsv_to_bgr(color_req_t r);
    logic [63:0] one, hue, sat, val, h6, frac, p, q, t, lr, lg, lb;
    logic [31:0] hue_rem, sat_rem, mixed;
    sector_t     sect;
    color_t      c;
    one = 64'd1 << FRAC_BITS;
    if (r.action == ACT_OBJECT_ID) begin
      // hash the id into hue and saturation, value is full scale
      mixed   = (r.object_id << 2) ^ HASH_MASK_HUE;
      hue_rem = mixed % 32'(HASH_MOD);
      mixed   = (r.object_id << 3) ^ HASH_MASK_SAT;
      sat_rem = mixed % 32'(HASH_MOD);
      hue = (64'(hue_rem) * one) / 64'(HASH_MOD);
      sat = (64'(sat_rem) * one) / 64'(HASH_MOD);
      val = one;
    end else begin
      hue = 64'(r.hue);
      sat = clip_one(64'(r.saturation));
      val = clip_one(64'(r.brightness));
    end
    h6   = hue * 64'(SECTORS);
    sect = sector_t'(h6 >> FRAC_BITS);
    frac = h6 & (one - 64'd1);
    p = (val * (one - sat)) >> FRAC_BITS;
    q = (val * (one - ((frac * sat) >> FRAC_BITS))) >> FRAC_BITS;
    t = (val * (one - (((one - frac) * sat) >> FRAC_BITS))) >> FRAC_BITS;
    case (sect)
      SECT_RED_YELLOW: begin
        lr = val; lg = t;   lb = p;
      end
      SECT_YELLOW_GREEN: begin
        lr = q;   lg = val; lb = p;
      end
      SECT_GREEN_CYAN: begin
        lr = p;   lg = val; lb = t;
      end
      SECT_CYAN_BLUE: begin
        lr = p;   lg = q;   lb = val;
      end
      SECT_BLUE_MAGENTA: begin
        lr = t;   lg = p;   lb = val;
      end
      SECT_MAGENTA_RED: begin
        lr = val; lg = p;   lb = q;
      end
      default: begin
        // hue at or past 1.0 gives white
        lr = one; lg = one; lb = one;
      end
    endcase
    c.blue  = level_byte(lb);
    c.green = level_byte(lg);
    c.red   = level_byte(lr);
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic add_req(logic act, logic [ID_W-1:0] id, logic [FIELD_W-1:0] h,
                         logic [FIELD_W-1:0] s, logic [FIELD_W-1:0] v);
    color_req_t r;
    r.action     = act;
    r.object_id  = id;
    r.hue        = h;
    r.saturation = s;
    r.brightness = v;
    pending_reqs.push_back(r);
  endtask

  // hue mostly in range, with sector edges, exactly 1.0 and the full 17 bits
  function automatic logic [FIELD_W-1:0] rand_hue();
    int pick;
    int k;
    pick = $urandom_range(9);
    if (pick <= 5)
      return FIELD_W'($urandom_range(65535));
    if (pick == 6)
      return FIX_ONE;
    if (pick == 7) begin
      k = $urandom_range(6, 1);
      return FIELD_W'((k * 65536) / 6 - 1 + $urandom_range(2));
    end
    return FIELD_W'($urandom());
  endfunction

  // saturation or brightness: in range, the two ends, or above 1.0
  function automatic logic [FIELD_W-1:0] rand_level();
    int pick;
    pick = $urandom_range(9);
    if (pick <= 5)
      return FIELD_W'($urandom_range(65536));
    if (pick == 6)
      return $urandom_range(1) ? FIX_ONE : '0;
    return FIELD_W'($urandom());
  endfunction

  task automatic add_random(int count);
    repeat (count) begin
      // ignored fields are randomized too, the block must not look at them
      add_req(logic'($urandom_range(1)), $urandom(), rand_hue(), rand_level(),
              rand_level());
    end
  endtask

  // sender holds off until every color in flight has come out
  task automatic drain_pipeline();
    @(posedge clk);
    hold_for_drain = 1'b1;
    @(negedge clk);
    @(posedge clk);
    wait (expected_colors.size() == 0);
    hold_for_drain = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // driver: changes the request ports at the falling edge
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    color_req_t r;
    // a request still waiting on the ports must stay put
    if (!(start && !req_taken)) begin
      if (pending_reqs.size() > 0 && !hold_for_drain &&
          $urandom_range(99) >= idle_pct) begin
        r = pending_reqs.pop_front();
        start         <= 1'b1;
        in_action     <= r.action;
        in_object_id  <= r.object_id;
        in_hue        <= r.hue;
        in_saturation <= r.saturation;
        in_brightness <= r.brightness;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: samples at the rising edge, predicts and checks
  // ---------------------------------------------------------------------------

  function automatic bit field_ok(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    color_req_t r;
    color_t     want;
    bit         ok;
    req_taken = start && !busy;
    if (req_taken) begin
      r.action     = in_action;
      r.object_id  = in_object_id;
      r.hue        = in_hue;
      r.saturation = in_saturation;
      r.brightness = in_brightness;
      expected_colors.push_back(hsv_to_bgr(r));
      if (in_action == ACT_OBJECT_ID) begin
        n_object_id++;
      end else begin
        n_hsv++;
        if (in_hue >= FIX_ONE)
          n_past_hue++;
      end
    end
    if (out_valid === 1'b1) begin
      if (expected_colors.size() == 0) begin
        $display("%0t: unexpected color, actual b=%0d g=%0d r=%0d", $time,
                 out_blue, out_green, out_red);
        failed = 1'b1;
      end else begin
        want = expected_colors.pop_front();
        ok = field_ok("blue", want.blue, out_blue);
        ok = field_ok("green", want.green, out_green) && ok;
        ok = field_ok("red", want.red, out_red) && ok;
        if (!ok)
          failed = 1'b1;
        n_checked++;
      end
    end
    // watchdog on forward progress
    if (req_taken || out_valid === 1'b1)
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d colors outstanding", $time,
               STALL_LIMIT, expected_colors.size());
      $display("hsv_to_bgr_color_top_tb failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence of the run
  // ---------------------------------------------------------------------------

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_action      = ACT_HSV;
    in_object_id   = '0;
    in_hue         = '0;
    in_saturation  = '0;
    in_brightness  = '0;
    idle_pct       = 15;
    hold_for_drain = 1'b0;
    req_taken      = 1'b0;
    failed         = 1'b0;
    stall_cycles   = 0;
    n_hsv          = 0;
    n_object_id    = 0;
    n_checked      = 0;
    n_past_hue     = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: corners of hue, saturation and brightness
    add_req(ACT_HSV, '0, '0, '0, '0);
    add_req(ACT_HSV, '0, '0, FIX_ONE, FIX_ONE);
    add_req(ACT_HSV, '0, 17'd65535, FIX_ONE, FIX_ONE);
    add_req(ACT_HSV, '0, FIX_ONE, FIX_ONE, FIX_ONE);          // hue exactly 1.0, white
    add_req(ACT_HSV, '0, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);    // everything past 1.0
    add_req(ACT_HSV, '0, 17'd10923, 17'h1FFFF, FIX_ONE);      // saturation clipped
    add_req(ACT_HSV, '0, 17'd21845, FIX_ONE, 17'h1FFFF);      // brightness clipped
    add_req(ACT_HSV, '0, 17'd10922, 17'd32768, 17'd65535);    // last hue of first sector
    // one request per sector, mid sector
    add_req(ACT_HSV, '0, 17'd5461, 17'd40000, 17'd50000);
    add_req(ACT_HSV, '0, 17'd16384, 17'd40000, 17'd50000);
    add_req(ACT_HSV, '0, 17'd27307, 17'd40000, 17'd50000);
    add_req(ACT_HSV, '0, 17'd38229, 17'd40000, 17'd50000);
    add_req(ACT_HSV, '0, 17'd49152, 17'd40000, 17'd50000);
    add_req(ACT_HSV, '0, 17'd60075, 17'd40000, 17'd50000);
    add_req(ACT_HSV, 32'hFFFF_FFFF, 17'd100, 17'd1, 17'd1);  // object id ignored
    // object id mode: hsv fields must be ignored
    add_req(ACT_OBJECT_ID, 32'h0000_0000, '0, '0, '0);
    add_req(ACT_OBJECT_ID, 32'hFFFF_FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
    add_req(ACT_OBJECT_ID, 32'h0000_0001, FIX_ONE, '0, '0);
    add_req(ACT_OBJECT_ID, 32'h8000_0000, '0, FIX_ONE, FIX_ONE);
    add_req(ACT_OBJECT_ID, 32'h4000_0000, '0, '0, '0);
    add_req(ACT_OBJECT_ID, 32'h0093_7151, '0, '0, '0);

    // first phase: the sender is mostly busy
    add_random(RAND_PER_PHASE);
    wait (pending_reqs.size() == 0);
    drain_pipeline();

    // second phase: the sender is mostly idle
    @(posedge clk);
    idle_pct = 73;
    add_random(RAND_PER_PHASE);
    wait (pending_reqs.size() == 0);
    drain_pipeline();

    // last phase: back to back requests
    @(posedge clk);
    idle_pct = 0;
    add_random(RAND_PER_PHASE);
    wait (pending_reqs.size() == 0 && !start);
    wait (expected_colors.size() == 0);
    // catch any stray strobe after the last expected color
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d requests: %0d hsv (%0d with hue at or past 1.0), %0d object id",
             n_hsv + n_object_id, n_hsv, n_past_hue, n_object_id);
    $display("%0d colors compared over busy, sparse and back to back pacing", n_checked);
    if (!failed) begin
      $display("hsv_to_bgr_color_top_tb passed");
    end else begin
      $display("hsv_to_bgr_color_top_tb failed");
    end
    $finish;
  end

endmodule
